// ===== hw/rtl/prwt_pkg.sv =====
// ----------------------------------------------------------------------------
// prwt_pkg
// Shared types and constants for the Prewitt gradient magnitude core.
// ----------------------------------------------------------------------------
package prwt_pkg;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_SQR  = 6'b000100,
    S_MUL  = 6'b001000,
    S_ROOT = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_GAIN   = 2'd2
  } reg_index_t;

  localparam int unsigned CFG_BITS = 16;
  localparam logic [7:0] MAG_MAX = 8'd255;
  localparam int unsigned DIM_MIN = 3;

endpackage

// ===== hw/rtl/prewitt_gradient_magnitude_core.sv =====
// ----------------------------------------------------------------------------
// prewitt_gradient_magnitude_core
// Streaming 3x3 Prewitt gradient magnitude over raster pixels, two line stores.
// ----------------------------------------------------------------------------
// One pixel word is taken at a time. A pixel that yields no result (border
// rows and columns) holds the input while the accept cycle issues the line
// store read and the next does the write back and the window update. An
// interior pixel holds the input through read, gradient, squares, the scale
// multiply, the bit-pair square root unit, and a final step that loads the
// result word into the output register. That load waits while an earlier
// result word is still stalled at the output. The output register is
// separate, so the next pixel may be taken while a result still waits.
// Result words appear when the lower-right pixel of a window arrives;
// row_end and frame_end mark the last interior result of a row and of a
// frame. Configuration must be written only while idle; the block itself
// does not enforce this.
module prewitt_gradient_magnitude_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [prwt_pkg::CFG_BITS-1:0] cfg_data,
  input  logic [7:0]                    pixel,
  input  logic                          frame_start,
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  output logic [7:0]                    magnitude,
  output logic                          row_end,
  output logic                          frame_end,
  output logic                          result_valid,
  input  logic                          result_ready
);

  localparam int unsigned CB = $clog2(MAX_WIDTH);
  localparam int unsigned RB = $clog2(MAX_HEIGHT);
  localparam int unsigned WCB = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HCB = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WX = (WCB > 11) ? WCB : 11;
  localparam int unsigned HX = (HCB > 11) ? HCB : 11;

  prwt_pkg::state_t state;

  logic [10:0] image_width;
  logic [10:0] image_height;
  logic [15:0] gain_q8;
  logic [31:0] gain_sq;

  logic [7:0] mem_upper [MAX_WIDTH];
  logic [7:0] mem_middle [MAX_WIDTH];
  logic [7:0] rd_upper;
  logic [7:0] rd_middle;

  logic [CB-1:0] col;
  logic [RB-1:0] row;
  logic [CB-1:0] c_in;
  logic [RB-1:0] r_in;
  logic [CB-1:0] c_q;
  logic [RB-1:0] r_q;
  logic [7:0] px_q;
  logic [7:0] win [6];

  logic [WX-1:0] w_cfg;
  logic [WX-1:0] w_eff;
  logic [HX-1:0] h_cfg;
  logic [HX-1:0] h_eff;
  logic last_col;
  logic last_row;
  logic interior;

  logic [9:0] sum_l;
  logic [9:0] sum_r;
  logic [9:0] sum_t;
  logic [9:0] sum_b;
  logic signed [10:0] gx;
  logic signed [10:0] gy;
  logic signed [21:0] gx_sq;
  logic signed [21:0] gy_sq;
  logic [20:0] s_sum;
  logic [52:0] prod;

  logic row_end_q;
  logic frame_end_q;

  logic [15:0] xr;
  logic [10:0] rem;
  logic [7:0] root;
  logic [2:0] cnt;
  logic sat;
  logic [10:0] rem_sh;
  logic [10:0] trial;

  logic accept;
  logic load;

  assign pixel_ready = (state == prwt_pkg::S_IDLE);
  assign accept = pixel_valid && pixel_ready;
  assign load = (state == prwt_pkg::S_DONE) && (!result_valid || result_ready);

  assign c_in = frame_start ? '0 : col;
  assign r_in = frame_start ? '0 : row;

  // clamp geometry to the supported range
  always_comb begin
    w_cfg = WX'(image_width);
    h_cfg = HX'(image_height);
    if (w_cfg < WX'(prwt_pkg::DIM_MIN)) begin
      w_eff = WX'(prwt_pkg::DIM_MIN);
    end else if (w_cfg > WX'(MAX_WIDTH)) begin
      w_eff = WX'(MAX_WIDTH);
    end else begin
      w_eff = w_cfg;
    end
    if (h_cfg < HX'(prwt_pkg::DIM_MIN)) begin
      h_eff = HX'(prwt_pkg::DIM_MIN);
    end else if (h_cfg > HX'(MAX_HEIGHT)) begin
      h_eff = HX'(MAX_HEIGHT);
    end else begin
      h_eff = h_cfg;
    end
  end

  assign last_col = WX'(c_q) >= (w_eff - WX'(1));
  assign last_row = HX'(r_q) >= (h_eff - HX'(1));
  assign interior = (c_q >= CB'(2)) && (r_q >= RB'(2));

  // n0 = upper, n1 = middle, n2 = incoming pixel
  assign sum_l = 10'(win[0]) + 10'(win[1]) + 10'(win[2]);
  assign sum_r = 10'(rd_upper) + 10'(rd_middle) + 10'(px_q);
  assign sum_t = 10'(win[0]) + 10'(win[3]) + 10'(rd_upper);
  assign sum_b = 10'(win[2]) + 10'(win[5]) + 10'(px_q);

  assign gx_sq = gx * gx;
  assign gy_sq = gy * gy;

  // first root step takes its digit pair straight from the product
  assign rem_sh = {rem[8:0], (cnt == '0) ? prod[31:30] : xr[15:14]};
  assign trial = {1'b0, root, 2'b01};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 11'd640;
      image_height <= 11'd480;
      gain_q8 <= 16'd256;
    end else if (cfg_write) begin
      unique case (cfg_index)
        prwt_pkg::REG_WIDTH:  image_width <= cfg_data[10:0];
        prwt_pkg::REG_HEIGHT: image_height <= cfg_data[10:0];
        prwt_pkg::REG_GAIN:   gain_q8 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    gain_sq <= 32'(gain_q8) * 32'(gain_q8);
  end

  // line stores: read on accept, write back in the next cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_upper <= mem_upper[c_in];
      rd_middle <= mem_middle[c_in];
    end
    if (state == prwt_pkg::S_READ) begin
      mem_upper[c_q] <= rd_middle;
      mem_middle[c_q] <= px_q;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c_q <= c_in;
      r_q <= r_in;
      px_q <= pixel;
    end
    if (state == prwt_pkg::S_READ) begin
      gx <= $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
      gy <= $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
      row_end_q <= last_col;
      frame_end_q <= last_col && last_row;
    end
    if (state == prwt_pkg::S_SQR) begin
      s_sum <= 21'(gx_sq[19:0]) + 21'(gy_sq[19:0]);
    end
    if (state == prwt_pkg::S_MUL) begin
      prod <= 53'(s_sum) * 53'(gain_sq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prwt_pkg::S_IDLE;
      col <= '0;
      row <= '0;
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
      result_valid <= 1'b0;
      xr <= '0;
      rem <= '0;
      root <= '0;
      cnt <= '0;
      sat <= 1'b0;
      magnitude <= '0;
      row_end <= 1'b0;
      frame_end <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        prwt_pkg::S_IDLE: begin
          if (accept) begin
            state <= prwt_pkg::S_READ;
          end
        end
        prwt_pkg::S_READ: begin
          win[0] <= win[3];
          win[1] <= win[4];
          win[2] <= win[5];
          win[3] <= rd_upper;
          win[4] <= rd_middle;
          win[5] <= px_q;
          if (last_col) begin
            col <= '0;
            row <= last_row ? '0 : r_q + RB'(1);
          end else begin
            col <= c_q + CB'(1);
            row <= r_q;
          end
          state <= interior ? prwt_pkg::S_SQR : prwt_pkg::S_IDLE;
        end
        prwt_pkg::S_SQR: begin
          state <= prwt_pkg::S_MUL;
        end
        prwt_pkg::S_MUL: begin
          state <= prwt_pkg::S_ROOT;
          cnt <= '0;
          rem <= '0;
          root <= '0;
        end
        prwt_pkg::S_ROOT: begin
          // result equals isqrt of the product >> 16
          if (cnt == '0) begin
            sat <= (prod[52:32] != '0);
            xr <= {prod[29:16], 2'b00};
          end else begin
            xr <= {xr[13:0], 2'b00};
          end
          if (rem_sh >= trial) begin
            rem <= rem_sh - trial;
            root <= {root[6:0], 1'b1};
          end else begin
            rem <= rem_sh;
            root <= {root[6:0], 1'b0};
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            state <= prwt_pkg::S_DONE;
          end
        end
        prwt_pkg::S_DONE: begin
          if (load) begin
            magnitude <= sat ? prwt_pkg::MAG_MAX : root;
            row_end <= row_end_q;
            frame_end <= frame_end_q;
            state <= prwt_pkg::S_IDLE;
          end
        end
        default: state <= prwt_pkg::S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/prwt_checker.sv =====
// ----------------------------------------------------------------------------
// prwt_checker
// Port-level checks for the Prewitt gradient magnitude core.
// ----------------------------------------------------------------------------
module prwt_checker (
  input logic       clk,
  input logic       rst,
  input logic       pixel_valid,
  input logic       pixel_ready,
  input logic [7:0] magnitude,
  input logic       row_end,
  input logic       frame_end,
  input logic       result_valid,
  input logic       result_ready
);

  // one word in flight: no second accept right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready |=> !pixel_ready)
    else $error("pixel taken back to back");

  // result_valid never rises in the cycle after a pixel is taken
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready |=> !$rose(result_valid))
    else $error("result too early");

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_end |-> row_end)
    else $error("frame end without row end");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(magnitude)
      && $stable(row_end) && $stable(frame_end))
    else $error("stalled result word changed");

endmodule

bind prewitt_gradient_magnitude_core prwt_checker u_prwt_checker (
  .clk(clk),
  .rst(rst),
  .pixel_valid(pixel_valid),
  .pixel_ready(pixel_ready),
  .magnitude(magnitude),
  .row_end(row_end),
  .frame_end(frame_end),
  .result_valid(result_valid),
  .result_ready(result_ready)
);
